### hw/rtl/gbfp_pkg.sv
package gbfp_pkg;

    localparam int unsigned PaddrW = 3;
    localparam int unsigned PdataW = 32;
    localparam int unsigned RegIdxW = 1;

    localparam logic [RegIdxW-1:0] REG_MAX_PAYLOAD_LEN = 1'b0;
    localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd512;

    localparam logic [7:0] SYNC_1    = 8'hB5;
    localparam logic [7:0] SYNC_2    = 8'h62;
    localparam logic [7:0] CLASS_NAV = 8'h01;
    localparam logic [7:0] CLASS_ACK = 8'h05;
    localparam logic [7:0] CLASS_CFG = 8'h06;
    localparam logic [7:0] ID_PVT    = 8'h07;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_CLASS,
        ST_ID,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CK_A,
        ST_CK_B
    } state_t;

    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic        pvt_header_seen;
    } result_t;

endpackage

### hw/rtl/gnss_binary_frame_parser_top.sv
// Each accepted byte's result is registered into the output entry, or into the skid entry while the output is held.
// Throughput: one byte per cycle; a two-entry output buffer keeps input
// flowing while a result waits, and s_ready drops only when both are full.
// Reset (synchronous, aresetn low): framer returns to sync hunt, sums and
// header registers clear, output buffer empties, max_payload_len = 512.
module gnss_binary_frame_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbfp_pkg::PaddrW-1:0]   paddr,
    input  logic [gbfp_pkg::PdataW-1:0]   pwdata,
    output logic [gbfp_pkg::PdataW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_frame_ok,
    output logic [7:0]                    m_msg_class,
    output logic [7:0]                    m_msg_id,
    output logic [15:0]                   m_payload_length,
    output logic                          m_data_valid,
    output logic [7:0]                    m_data_byte,
    output logic [15:0]                   m_data_index,
    output logic                          m_pvt_header_seen
);
    import gbfp_pkg::*;

    logic [15:0] max_len_reg;
    logic        reg_sel;

    state_t      state_reg, state_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  frame_class_reg, frame_class_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] idx_inc;
    logic [7:0]  sum_a_add, sum_b_add;

    result_t     res;
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        accept;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PaddrW-1 -: RegIdxW] == REG_MAX_PAYLOAD_LEN);
    assign prdata  = reg_sel ? {{(PdataW-16){1'b0}}, max_len_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_PAYLOAD_LEN_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            max_len_reg <= pwdata[15:0];
        end
    end

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign sum_a_add = sum_a_reg + s_rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign idx_inc   = idx_reg + 16'd1;

    always_comb begin
        state_next        = state_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        frame_class_next  = frame_class_reg;
        frame_id_next     = frame_id_reg;
        frame_length_next = frame_length_reg;
        idx_next          = idx_reg;
        res               = '0;
        unique case (state_reg)
            ST_HUNT: begin
                sum_a_next = '0;
                sum_b_next = '0;
                state_next = (s_rx_byte == SYNC_1) ? ST_SYNC2 : ST_HUNT;
            end
            ST_SYNC2: begin
                if (s_rx_byte == SYNC_1) begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                end else if (s_rx_byte == SYNC_2) begin
                    state_next = ST_CLASS;
                end else begin
                    state_next = ST_HUNT;
                end
            end
            ST_CLASS: begin
                if (s_rx_byte == CLASS_NAV || s_rx_byte == CLASS_ACK
                        || s_rx_byte == CLASS_CFG) begin
                    frame_class_next = s_rx_byte;
                    sum_a_next       = sum_a_add;
                    sum_b_next       = sum_b_add;
                    state_next       = ST_ID;
                end else begin
                    state_next = ST_HUNT;
                end
            end
            ST_ID: begin
                frame_id_next       = s_rx_byte;
                sum_a_next          = sum_a_add;
                sum_b_next          = sum_b_add;
                res.pvt_header_seen = (frame_class_reg == CLASS_NAV) && (s_rx_byte == ID_PVT);
                state_next          = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                frame_length_next = {8'h00, s_rx_byte};
                sum_a_next        = sum_a_add;
                sum_b_next        = sum_b_add;
                state_next        = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                frame_length_next = {s_rx_byte, frame_length_reg[7:0]};
                if (frame_length_next > max_len_reg) begin
                    state_next = ST_HUNT;
                end else begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    idx_next   = '0;
                    state_next = (frame_length_next == 16'd0) ? ST_CK_A : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                res.data_valid = 1'b1;
                res.data_byte  = s_rx_byte;
                res.data_index = idx_reg;
                sum_a_next     = sum_a_add;
                sum_b_next     = sum_b_add;
                idx_next       = idx_inc;
                if (idx_inc == frame_length_reg) begin
                    state_next = ST_CK_A;
                end
            end
            ST_CK_A: begin
                state_next = (s_rx_byte == sum_a_reg) ? ST_CK_B : ST_HUNT;
            end
            ST_CK_B: begin
                res.frame_ok = (s_rx_byte == sum_b_reg);
                state_next   = ST_HUNT;
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
        res.msg_class      = frame_class_next;
        res.msg_id         = frame_id_next;
        res.payload_length = frame_length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_HUNT;
            sum_a_reg        <= '0;
            sum_b_reg        <= '0;
            frame_class_reg  <= '0;
            frame_id_reg     <= '0;
            frame_length_reg <= '0;
            idx_reg          <= '0;
        end else if (accept) begin
            state_reg        <= state_next;
            sum_a_reg        <= sum_a_next;
            sum_b_reg        <= sum_b_next;
            frame_class_reg  <= frame_class_next;
            frame_id_reg     <= frame_id_next;
            frame_length_reg <= frame_length_next;
            idx_reg          <= idx_next;
        end
    end

    // hold results in a two-entry buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_frame_ok        = out_reg.frame_ok;
    assign m_msg_class       = out_reg.msg_class;
    assign m_msg_id          = out_reg.msg_id;
    assign m_payload_length  = out_reg.payload_length;
    assign m_data_valid      = out_reg.data_valid;
    assign m_data_byte       = out_reg.data_byte;
    assign m_data_index      = out_reg.data_index;
    assign m_pvt_header_seen = out_reg.pvt_header_seen;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

    a_ok_not_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_ok && m_data_valid))
        else $error("frame_ok on a payload byte");

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAYLOAD) |-> (idx_reg < frame_length_reg))
        else $error("payload index beyond frame length");

endmodule
